>>> rtl/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int SEQ_BITS     = 8;
   localparam int PAYLOAD_BITS = 64;
   localparam int TIMER_BITS   = 16;
   localparam int WIN_BITS     = 4;
   localparam int FLIGHT_BITS  = 4;

   // func codes on the request channel
   localparam logic [1:0] FUNC_SEND = 2'd0;
   localparam logic [1:0] FUNC_ACK  = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // kind codes on the response channel
   localparam logic [1:0] KIND_NEW     = 2'd0;
   localparam logic [1:0] KIND_RESENT  = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   // register indexes (byte address 4*index)
   localparam logic REG_WINDOW  = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam logic [WIN_BITS-1:0]   WINDOW_RESET  = 4'd4;
   localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [WIN_BITS-1:0]   win_limit;
      logic [TIMER_BITS-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [SEQ_BITS-1:0]     seq_number;
      logic [PAYLOAD_BITS-1:0] packet_data;
      logic                    last;
      logic [FLIGHT_BITS-1:0]  in_flight;
   } beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/gbn_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_store
// Payload ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbn_store
   import gbn_pkg::*;
#(
   parameter int WINDOW_MAX = 8,
   parameter int IDX_BITS   = 3
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [IDX_BITS-1:0]     wr_addr,
   input  wire logic [PAYLOAD_BITS-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [IDX_BITS-1:0]     rd_addr,
   output logic      [PAYLOAD_BITS-1:0] rd_data
);

   logic [PAYLOAD_BITS-1:0] mem [WINDOW_MAX];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/gbn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window state, retransmit timer, resend sequencer and response register.
// ----------------------------------------------------------------------------
module gbn_ctrl
   import gbn_pkg::*;
#(
   parameter int WINDOW_MAX = 8,
   parameter int IDX_BITS   = 3,
   parameter int CNT_BITS   = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_func,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [SEQ_BITS-1:0]     req_ack_number,
   input  wire logic                    req_ack_intact,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output beat_type                     rsp_beat,
   output logic                         wr_en,
   output logic [IDX_BITS-1:0]          wr_addr,
   output logic [PAYLOAD_BITS-1:0]      wr_data,
   output logic                         rd_en,
   output logic [IDX_BITS-1:0]          rd_addr,
   input  wire logic [PAYLOAD_BITS-1:0] rd_data
);

   localparam logic [SEQ_BITS-1:0] WIN_MAX = SEQ_BITS'(WINDOW_MAX);

   // ring slot arithmetic: slot index plus an offset of at most WINDOW_MAX
   function automatic logic [IDX_BITS-1:0] wrap(input logic [SEQ_BITS-1:0] s);
      logic [SEQ_BITS-1:0] r;
      r = (s >= WIN_MAX) ? (s - WIN_MAX) : s;
      return IDX_BITS'(r);
   endfunction

   state_type             state_ff, state_in;
   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS-1:0]   next_ff, next_in;
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic                  run_ff, run_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   beat_type              beat_ff, beat_in;

   logic [SEQ_BITS-1:0]   n;
   logic [SEQ_BITS-1:0]   eff_win;
   logic [TIMER_BITS-1:0] eff_to;
   logic [SEQ_BITS-1:0]   ack_d;
   logic [SEQ_BITS-1:0]   ack_next;
   logic                  out_free;
   logic                  is_last;

   assign n        = next_ff - base_ff;
   assign ack_d    = req_ack_number - base_ff;
   assign ack_next = req_ack_number + SEQ_BITS'(1);
   assign out_free = !valid_ff || rsp_ready;
   assign is_last  = (SEQ_BITS'(idx_ff) + SEQ_BITS'(1)) == n;

   always_comb begin
      if (cfg.win_limit == '0) begin
         eff_win = SEQ_BITS'(1);
      end else if (SEQ_BITS'(cfg.win_limit) > WIN_MAX) begin
         eff_win = WIN_MAX;
      end else begin
         eff_win = SEQ_BITS'(cfg.win_limit);
      end
      eff_to = (cfg.timeout_ticks == '0) ? TIMER_BITS'(1) : cfg.timeout_ticks;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         next_ff  <= '0;
         head_ff  <= '0;
         run_ff   <= 1'b0;
         count_ff <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         head_ff  <= head_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      next_in   = next_ff;
      head_in   = head_ff;
      run_in    = run_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_ready;
      beat_in   = beat_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wrap(SEQ_BITS'(head_ff) + n);
      wr_data   = req_payload;
      rd_en     = 1'b0;
      rd_addr   = wrap(SEQ_BITS'(head_ff) + SEQ_BITS'(idx_ff));

      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               case (req_func)
                  FUNC_SEND: begin
                     valid_in     = 1'b1;
                     beat_in.last = 1'b1;
                     if (n >= eff_win) begin
                        beat_in.kind        = KIND_REFUSED;
                        beat_in.seq_number  = '0;
                        beat_in.packet_data = '0;
                        beat_in.in_flight   = FLIGHT_BITS'(n);
                     end else begin
                        wr_en               = 1'b1;
                        beat_in.kind        = KIND_NEW;
                        beat_in.seq_number  = next_ff;
                        beat_in.packet_data = req_payload;
                        beat_in.in_flight   = FLIGHT_BITS'(n + SEQ_BITS'(1));
                        next_in             = next_ff + SEQ_BITS'(1);
                        if (n == '0) begin
                           run_in   = 1'b1;
                           count_in = '0;
                        end
                     end
                  end
                  FUNC_ACK: begin
                     if (req_ack_intact && (ack_d < n)) begin
                        base_in  = ack_next;
                        head_in  = wrap(SEQ_BITS'(head_ff) + ack_d + SEQ_BITS'(1));
                        count_in = '0;
                        run_in   = (ack_next != next_ff);
                     end
                  end
                  FUNC_TICK: begin
                     if (run_ff) begin
                        if (({1'b0, count_ff} + (TIMER_BITS+1)'(1)) < {1'b0, eff_to}) begin
                           count_in = count_ff + TIMER_BITS'(1);
                        end else begin
                           count_in = '0;
                           idx_in   = '0;
                           if (n != '0) begin
                              state_in = ST_READ;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in            = 1'b1;
               beat_in.kind        = KIND_RESENT;
               beat_in.seq_number  = base_ff + SEQ_BITS'(idx_ff);
               beat_in.packet_data = rd_data;
               beat_in.last        = is_last;
               beat_in.in_flight   = FLIGHT_BITS'(n);
               idx_in              = idx_ff + CNT_BITS'(1);
               state_in            = is_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

`default_nettype wire

>>> rtl/go_back_n_sender_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-Back-N ARQ sender with APB register port and stream channels.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* stream carries one command per beat: tuser selects send (0),
//    ack (1) or timer tick (2). Code 3 is dropped.
//  - rsp_* stream carries emitted packets: new sends, refusals and timeout
//    resends. tlast marks the final beat caused by one request.
//  - csr_* APB port holds the window limit (0x0) and timeout_ticks (0x4).
//    Write only while the block is idle.
//  - A send, ack or tick completes at acceptance; a send or refusal shows up on
//    rsp in the cycle after acceptance, from the output register.
//  - A timeout streams all outstanding packets oldest first: each beat is a
//    payload memory read, then a load of the output register that waits while
//    it is full. Requests are held off until the last resend beat is loaded.
//  - Requests are accepted while the output register is empty or drains in
//    the same cycle; a stalled receiver therefore stalls req as well.
//  - Reset (synchronous) empties the window, stops the timer and restores the
//    register defaults. The payload memory is not cleared; it is only read at
//    entries written by earlier sends.
// ----------------------------------------------------------------------------
module go_back_n_sender_top
   import gbn_pkg::*;
#(
   parameter int WINDOW_MAX = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // payload[63:0], ack_number[71:64], ack_intact[72]
   input  wire logic [1:0]  req_tuser,  // func[1:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,  // seq_number[7:0], packet_data[71:8], in_flight[75:72]
   output logic [1:0]       rsp_tuser,  // kind[1:0]
   output logic             rsp_tlast,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);

   logic [WIN_BITS-1:0]   window_ff;
   logic [TIMER_BITS-1:0] timeout_ff;
   logic                  csr_wr;
   logic                  csr_sel;
   cfg_type               cfg;
   beat_type              beat;

   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   logic [PAYLOAD_BITS-1:0] wr_data;
   logic                    rd_en;
   logic [IDX_BITS-1:0]     rd_addr;
   logic [PAYLOAD_BITS-1:0] rd_data;

   // register file: index lives in paddr[2], low address bits ignored
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         if (csr_sel == REG_WINDOW) begin
            window_ff <= csr_pwdata[WIN_BITS-1:0];
         end else begin
            timeout_ff <= csr_pwdata[TIMER_BITS-1:0];
         end
      end
   end

   assign csr_prdata = (csr_sel == REG_TIMEOUT) ? 32'(timeout_ff) : 32'(window_ff);

   assign cfg.win_limit     = window_ff;
   assign cfg.timeout_ticks = timeout_ff;

   gbn_ctrl #(
      .WINDOW_MAX (WINDOW_MAX),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_func       (req_tuser),
      .req_payload    (req_tdata[63:0]),
      .req_ack_number (req_tdata[71:64]),
      .req_ack_intact (req_tdata[72]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_beat       (beat),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   gbn_store #(
      .WINDOW_MAX (WINDOW_MAX),
      .IDX_BITS   (IDX_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = {4'b0, beat.in_flight, beat.packet_data, beat.seq_number};
   assign rsp_tuser = beat.kind;
   assign rsp_tlast = beat.last;

endmodule

`default_nettype wire
